// ===== design/ove_pkg.sv =====
// shared constants, types and helper functions of the octahedral vector encoder
`default_nettype none

package ove_pkg;

  // component and arithmetic widths
  localparam int COMP_W  = 16;           // input component width
  localparam int MAG_W   = COMP_W;       // magnitude of a component, most negative included
  localparam int SUM_W   = COMP_W + 1;   // l1 norm of three magnitudes
  localparam int DIV_W   = SUM_W + 1;    // divisor, twice the norm
  localparam int SNORM_W = 16;
  localparam int UNORM_W = 8;
  localparam int QUO_W   = SNORM_W - 1;  // quotient bits per lane
  localparam int NUM_W   = SUM_W + SNORM_W;

  // divider pipeline shape
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  // divider lanes
  localparam int LANES   = 4;
  localparam int LANE_NU = 0;
  localparam int LANE_NV = 1;
  localparam int LANE_TU = 2;
  localparam int LANE_TV = 3;

  // fixed tangent bytes
  localparam logic [UNORM_W-1:0] TANGENT_MID      = UNORM_W'(128);
  localparam logic [UNORM_W-1:0] TANGENT_SIGN_POS = {UNORM_W{1'b1}};
  localparam logic [UNORM_W-1:0] TANGENT_SIGN_NEG = '0;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // sideband that travels alongside the divider lanes
  typedef struct packed {
    logic su;
    logic sv;
    logic hand;
    logic zero;
  } side_t;

  // projected vector after the first front stage
  typedef struct packed {
    side_t side;
    sum_t  sum;
    sum_t  mu;
    sum_t  mv;
  } proj_t;

  // one restoring-division lane: partial remainder plus merged numerator/quotient shifter
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] nq;
  } lane_t;

  typedef struct packed {
    side_t            side;
    logic [DIV_W-1:0] dvsr;
    lane_t [LANES-1:0] lane;
  } div_t;

  // magnitude of a two's complement component
  function automatic mag_t mag_of(comp_t v);
    mag_t m;
    m = v[COMP_W-1] ? (~v + MAG_W'(1)) : v;
    return m;
  endfunction

  // load a numerator: the high bits start the remainder, the low bits shift in later
  function automatic lane_t lane_init(logic [NUM_W-1:0] n);
    lane_t l;
    l.rem = n[NUM_W-1:QUO_W];
    l.nq  = n[QUO_W-1:0];
    return l;
  endfunction

  // one restoring division step, one quotient bit
  function automatic lane_t div_step(lane_t l, logic [DIV_W-1:0] d);
    logic [DIV_W:0] r;
    logic           qbit;
    lane_t          o;
    r    = {l.rem, l.nq[QUO_W-1]};
    qbit = (r >= {1'b0, d});
    if (qbit) begin
      r = r - {1'b0, d};
    end
    o.rem = r[DIV_W-1:0];
    o.nq  = {l.nq[QUO_W-2:0], qbit};
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== design/ove_if.sv =====
// stream interfaces for the encoder input vectors and encoded results
`default_nettype none

interface ove_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ove_pkg::COMP_W-1:0]    vec_x;
  logic signed [ove_pkg::COMP_W-1:0]    vec_y;
  logic signed [ove_pkg::COMP_W-1:0]    vec_z;
  logic                                 handedness;

  modport source (output valid, vec_x, vec_y, vec_z, handedness, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, handedness, output ready);
endinterface

interface ove_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ove_pkg::SNORM_W-1:0]   normal_u;
  logic signed [ove_pkg::SNORM_W-1:0]   normal_v;
  logic        [ove_pkg::UNORM_W-1:0]   tangent_u;
  logic        [ove_pkg::UNORM_W-1:0]   tangent_v;
  logic        [ove_pkg::UNORM_W-1:0]   tangent_mid;
  logic        [ove_pkg::UNORM_W-1:0]   tangent_sign;
  logic                                 zero_vector;

  modport source (output valid, normal_u, normal_v, tangent_u, tangent_v, tangent_mid,
                  tangent_sign, zero_vector, input ready);
  modport sink   (input valid, normal_u, normal_v, tangent_u, tangent_v, tangent_mid,
                  tangent_sign, zero_vector, output ready);
endinterface

`default_nettype wire

// ===== design/ove_front.sv =====
// front stages: magnitudes, l1 norm, fold, and divider numerators
`default_nettype none

module ove_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ove_in_if.sink             vec_in,
  output ove_pkg::div_t      dout,
  output logic               dout_valid,
  input  wire logic          dout_ready
);

  ove_pkg::mag_t  mx, my, mz;
  ove_pkg::sum_t  sum;
  ove_pkg::proj_t proj;
  ove_pkg::proj_t p1;
  logic           v1;
  logic           ready1;
  logic           ready2;

  logic [ove_pkg::SUM_W:0]   tu, tv;
  logic [ove_pkg::NUM_W-1:0] n_nu, n_nv, n_tu, n_tv;
  ove_pkg::div_t             d_next;

  // stage 1: sign split, norm and hemisphere fold
  always_comb begin
    mx  = ove_pkg::mag_of(vec_in.vec_x);
    my  = ove_pkg::mag_of(vec_in.vec_y);
    mz  = ove_pkg::mag_of(vec_in.vec_z);
    sum = ove_pkg::SUM_W'(mx) + ove_pkg::SUM_W'(my) + ove_pkg::SUM_W'(mz);
    proj.side.su   = vec_in.vec_x[ove_pkg::COMP_W-1];
    proj.side.sv   = vec_in.vec_y[ove_pkg::COMP_W-1];
    proj.side.hand = vec_in.handedness;
    proj.side.zero = (sum == '0);
    proj.sum       = sum;
    if (vec_in.vec_z[ove_pkg::COMP_W-1]) begin
      proj.mu = sum - ove_pkg::SUM_W'(my);
      proj.mv = sum - ove_pkg::SUM_W'(mx);
    end else begin
      proj.mu = ove_pkg::SUM_W'(mx);
      proj.mv = ove_pkg::SUM_W'(my);
    end
  end

  assign ready1       = !v1 || ready2;
  assign vec_in.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= vec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && vec_in.valid) begin
      p1 <= proj;
    end
  end

  // stage 2: numerators mag*(2*32767)+s and 255*t+s, divisor 2s
  always_comb begin
    tu = p1.side.su ? ({1'b0, p1.sum} - {1'b0, p1.mu}) : ({1'b0, p1.sum} + {1'b0, p1.mu});
    tv = p1.side.sv ? ({1'b0, p1.sum} - {1'b0, p1.mv}) : ({1'b0, p1.sum} + {1'b0, p1.mv});
    n_nu = (ove_pkg::NUM_W'(p1.mu) << ove_pkg::SNORM_W) - (ove_pkg::NUM_W'(p1.mu) << 1)
         + ove_pkg::NUM_W'(p1.sum);
    n_nv = (ove_pkg::NUM_W'(p1.mv) << ove_pkg::SNORM_W) - (ove_pkg::NUM_W'(p1.mv) << 1)
         + ove_pkg::NUM_W'(p1.sum);
    n_tu = (ove_pkg::NUM_W'(tu) << ove_pkg::UNORM_W) - ove_pkg::NUM_W'(tu)
         + ove_pkg::NUM_W'(p1.sum);
    n_tv = (ove_pkg::NUM_W'(tv) << ove_pkg::UNORM_W) - ove_pkg::NUM_W'(tv)
         + ove_pkg::NUM_W'(p1.sum);
    d_next.side                  = p1.side;
    d_next.dvsr                  = {p1.sum, 1'b0};
    d_next.lane[ove_pkg::LANE_NU] = ove_pkg::lane_init(n_nu);
    d_next.lane[ove_pkg::LANE_NV] = ove_pkg::lane_init(n_nv);
    d_next.lane[ove_pkg::LANE_TU] = ove_pkg::lane_init(n_tu);
    d_next.lane[ove_pkg::LANE_TV] = ove_pkg::lane_init(n_tv);
  end

  assign ready2 = !dout_valid || dout_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (ready2) begin
      dout_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      dout <= d_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ove_div_stage.sv =====
// one divider pipeline stage: a few restoring steps on all four lanes
`default_nettype none

module ove_div_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ove_pkg::div_t din,
  input  wire logic          din_valid,
  output logic               din_ready,
  output ove_pkg::div_t      dout,
  output logic               dout_valid,
  input  wire logic          dout_ready
);

  ove_pkg::div_t d_next;

  // quotient bits for this stage, msb first
  always_comb begin
    d_next = din;
    for (int ln = 0; ln < ove_pkg::LANES; ln++) begin
      for (int st = 0; st < ove_pkg::STEPS_PER_STAGE; st++) begin
        d_next.lane[ln] = ove_pkg::div_step(d_next.lane[ln], din.dvsr);
      end
    end
  end

  assign din_ready = !dout_valid || dout_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (din_ready) begin
      dout_valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din_ready && din_valid) begin
      dout <= d_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ove_pack.sv =====
// output stage: sign application, tangent bytes and result register
`default_nettype none

module ove_pack (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ove_pkg::div_t din,
  input  wire logic          din_valid,
  output logic               din_ready,
  ove_out_if.source          enc_out
);

  logic [ove_pkg::QUO_W-1:0]   q_nu, q_nv;
  logic [ove_pkg::SNORM_W-1:0] nu_abs, nv_abs;
  logic [ove_pkg::SNORM_W-1:0] nu_next, nv_next;
  logic [ove_pkg::UNORM_W-1:0] tu_next, tv_next, mid_next, sign_next;

  logic                        valid;
  logic [ove_pkg::SNORM_W-1:0] normal_u, normal_v;
  logic [ove_pkg::UNORM_W-1:0] tangent_u, tangent_v, tangent_mid, tangent_sign;
  logic                        zero_vector;

  // apply signs and fixed bytes, all zero for a zero vector
  always_comb begin
    q_nu   = din.lane[ove_pkg::LANE_NU].nq;
    q_nv   = din.lane[ove_pkg::LANE_NV].nq;
    nu_abs = {1'b0, q_nu};
    nv_abs = {1'b0, q_nv};
    if (din.side.zero) begin
      nu_next   = '0;
      nv_next   = '0;
      tu_next   = '0;
      tv_next   = '0;
      mid_next  = '0;
      sign_next = '0;
    end else begin
      nu_next   = din.side.su ? (~nu_abs + ove_pkg::SNORM_W'(1)) : nu_abs;
      nv_next   = din.side.sv ? (~nv_abs + ove_pkg::SNORM_W'(1)) : nv_abs;
      tu_next   = din.lane[ove_pkg::LANE_TU].nq[ove_pkg::UNORM_W-1:0];
      tv_next   = din.lane[ove_pkg::LANE_TV].nq[ove_pkg::UNORM_W-1:0];
      mid_next  = ove_pkg::TANGENT_MID;
      sign_next = din.side.hand ? ove_pkg::TANGENT_SIGN_POS : ove_pkg::TANGENT_SIGN_NEG;
    end
  end

  assign din_ready = !valid || enc_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (din_ready) begin
      valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din_ready && din_valid) begin
      normal_u     <= nu_next;
      normal_v     <= nv_next;
      tangent_u    <= tu_next;
      tangent_v    <= tv_next;
      tangent_mid  <= mid_next;
      tangent_sign <= sign_next;
      zero_vector  <= din.side.zero;
    end
  end

  assign enc_out.valid        = valid;
  assign enc_out.normal_u     = normal_u;
  assign enc_out.normal_v     = normal_v;
  assign enc_out.tangent_u    = tangent_u;
  assign enc_out.tangent_v    = tangent_v;
  assign enc_out.tangent_mid  = tangent_mid;
  assign enc_out.tangent_sign = tangent_sign;
  assign enc_out.zero_vector  = zero_vector;

endmodule

`default_nettype wire

// ===== design/octahedral_vector_encoder_top.sv =====
// top level of the octahedral vector encoder pipeline
//
// vec_in takes one signed 3-component vector plus a handedness bit per
// transaction (valid/ready). enc_out returns one result per transaction: an
// snorm16 octahedral pair, a tangent quad of unorm8 bytes and a zero-vector
// flag, exactly rounded, halves away from zero.
// An accepted input passes through two front stages (norm and fold, then numerator
// forming), five divider stages of three restoring steps each over 15 quotient bits,
// and the output register before it appears as a valid result.
// Throughput is one transaction per cycle while enc_out does not stall; every stage
// holds one item and carries its own valid bit.
// A stall on enc_out holds the output register; each stage takes new data
// when it is empty or its successor moves, so bubbles are squeezed out and
// vec_in keeps accepting until all eight stages are full.
// rst (synchronous) clears all valid bits; the data registers are not reset, and
// there is no warm-up period after reset.
`default_nettype none

module octahedral_vector_encoder_top (
  input  wire logic  clk,
  input  wire logic  rst,
  ove_in_if.sink     vec_in,
  ove_out_if.source  enc_out
);

  ove_pkg::div_t stage_data  [ove_pkg::DIV_STAGES+1];
  logic          stage_valid [ove_pkg::DIV_STAGES+1];
  logic          stage_ready [ove_pkg::DIV_STAGES+1];

  ove_front u_front (
    .clk        (clk),
    .rst        (rst),
    .vec_in     (vec_in),
    .dout       (stage_data[0]),
    .dout_valid (stage_valid[0]),
    .dout_ready (stage_ready[0])
  );

  // divider pipeline
  for (genvar g = 0; g < ove_pkg::DIV_STAGES; g++) begin : g_div
    ove_div_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .din        (stage_data[g]),
      .din_valid  (stage_valid[g]),
      .din_ready  (stage_ready[g]),
      .dout       (stage_data[g+1]),
      .dout_valid (stage_valid[g+1]),
      .dout_ready (stage_ready[g+1])
    );
  end

  ove_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .din       (stage_data[ove_pkg::DIV_STAGES]),
    .din_valid (stage_valid[ove_pkg::DIV_STAGES]),
    .din_ready (stage_ready[ove_pkg::DIV_STAGES]),
    .enc_out   (enc_out)
  );

  // zero vector gives an all-zero result
  a_zero_clear: assert property (@(posedge clk) disable iff (rst)
    (enc_out.valid && enc_out.zero_vector) |->
      (enc_out.normal_u == '0 && enc_out.normal_v == '0 && enc_out.tangent_u == '0 &&
       enc_out.tangent_v == '0 && enc_out.tangent_mid == '0 && enc_out.tangent_sign == '0))
    else $error("zero vector result not cleared");

  // snorm never reaches the most negative code
  a_snorm_range: assert property (@(posedge clk) disable iff (rst)
    enc_out.valid |->
      (enc_out.normal_u != {1'b1, {(ove_pkg::SNORM_W-1){1'b0}}} &&
       enc_out.normal_v != {1'b1, {(ove_pkg::SNORM_W-1){1'b0}}}))
    else $error("snorm result out of range");

  // snorm sign and unorm half must agree
  a_sign_agree: assert property (@(posedge clk) disable iff (rst)
    (enc_out.valid && !enc_out.zero_vector) |->
      ((enc_out.normal_u[ove_pkg::SNORM_W-1] == !enc_out.tangent_u[ove_pkg::UNORM_W-1] ||
        enc_out.normal_u == '0) &&
       (enc_out.normal_v[ove_pkg::SNORM_W-1] == !enc_out.tangent_v[ove_pkg::UNORM_W-1] ||
        enc_out.normal_v == '0)))
    else $error("snorm and unorm results disagree in sign");

  // fixed tangent bytes on a nonzero vector
  a_fixed_bytes: assert property (@(posedge clk) disable iff (rst)
    (enc_out.valid && !enc_out.zero_vector) |->
      (enc_out.tangent_mid == ove_pkg::TANGENT_MID &&
       (enc_out.tangent_sign == ove_pkg::TANGENT_SIGN_POS ||
        enc_out.tangent_sign == ove_pkg::TANGENT_SIGN_NEG)))
    else $error("tangent fixed bytes wrong");

endmodule

`default_nettype wire

// ===== verif/tb_octahedral_vector_encoder_top.sv =====
// self-checking testbench for the octahedral vector encoder top level
`timescale 1ns / 100ps

module tb_octahedral_vector_encoder_top;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 16;
  localparam int ITEMS_PER_PASS = 395;
  localparam int MAX_PRINTS     = 30;

  localparam longint unsigned SNORM_MAX = 32767;
  localparam longint unsigned UNORM_MAX = 255;

  // one encoded result as it leaves the block
  typedef struct packed {
    logic [ove_pkg::SNORM_W-1:0] normal_u;
    logic [ove_pkg::SNORM_W-1:0] normal_v;
    logic [ove_pkg::UNORM_W-1:0] tangent_u;
    logic [ove_pkg::UNORM_W-1:0] tangent_v;
    logic [ove_pkg::UNORM_W-1:0] tangent_mid;
    logic [ove_pkg::UNORM_W-1:0] tangent_sign;
    logic                        zero_vector;
  } enc_code_t;

  // predicts the encoding of each accepted vector and checks returned codes in order
  class octa_code_tracker;
    enc_code_t pending_codes[$];
    int errors      = 0;
    int printed     = 0;
    int vectors_in  = 0;
    int codes_out   = 0;
    int zero_seen   = 0;
    int folded_seen = 0;

    function longint unsigned magnitude(ove_pkg::comp_t v);
      longint unsigned u;
      u = v;
      if (v[ove_pkg::COMP_W-1]) begin
        u = (longint'(1) << ove_pkg::COMP_W) - u;
      end
      return u;
    endfunction

    // round(sign * mag / s * 32767), halves away from zero
    function logic [ove_pkg::SNORM_W-1:0] snorm_of(logic neg, longint unsigned mag,
                                                   longint unsigned s);
      longint unsigned q;
      q = (mag * 2 * SNORM_MAX + s) / (2 * s);
      return neg ? ove_pkg::SNORM_W'(0 - q) : ove_pkg::SNORM_W'(q);
    endfunction

    // round((sign * mag / s + 1) / 2 * 255)
    function logic [ove_pkg::UNORM_W-1:0] unorm_of(logic neg, longint unsigned mag,
                                                   longint unsigned s);
      longint unsigned t;
      t = neg ? (s - mag) : (s + mag);
      return ove_pkg::UNORM_W'((UNORM_MAX * t + s) / (2 * s));
    endfunction

    function enc_code_t encode_vector(ove_pkg::comp_t x, ove_pkg::comp_t y,
                                      ove_pkg::comp_t z, logic hand);
      longint unsigned mx, my, mz, s, mu, mv;
      enc_code_t c;
      mx = magnitude(x);
      my = magnitude(y);
      mz = magnitude(z);
      s  = mx + my + mz;
      c  = '0;
      if (s == 0) begin
        c.zero_vector = 1'b1;
        return c;
      end
      // lower hemisphere folds over the diagonals
      if (z[ove_pkg::COMP_W-1]) begin
        mu = s - my;
        mv = s - mx;
      end else begin
        mu = mx;
        mv = my;
      end
      c.normal_u     = snorm_of(x[ove_pkg::COMP_W-1], mu, s);
      c.normal_v     = snorm_of(y[ove_pkg::COMP_W-1], mv, s);
      c.tangent_u    = unorm_of(x[ove_pkg::COMP_W-1], mu, s);
      c.tangent_v    = unorm_of(y[ove_pkg::COMP_W-1], mv, s);
      c.tangent_mid  = ove_pkg::TANGENT_MID;
      c.tangent_sign = hand ? ove_pkg::TANGENT_SIGN_POS : ove_pkg::TANGENT_SIGN_NEG;
      return c;
    endfunction

    function void note_vector(ove_pkg::comp_t x, ove_pkg::comp_t y, ove_pkg::comp_t z,
                              logic hand);
      enc_code_t c;
      c = encode_vector(x, y, z, hand);
      pending_codes = {pending_codes, c};
      vectors_in++;
      if (c.zero_vector) zero_seen++;
      else if (z[ove_pkg::COMP_W-1]) folded_seen++;
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (printed < MAX_PRINTS) begin
        printed++;
        $display("mismatch at %0t, result %0d: %s got %0h expected %0h",
                 $time, codes_out, what, got, want);
      end
    endtask

    task check_code(enc_code_t got);
      enc_code_t want;
      if (pending_codes.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(got.normal_u), 0);
        return;
      end
      want = pending_codes.pop_front();
      codes_out++;
      if (got.normal_u !== want.normal_u)
        report_mismatch("normal_u", 32'(got.normal_u), 32'(want.normal_u));
      if (got.normal_v !== want.normal_v)
        report_mismatch("normal_v", 32'(got.normal_v), 32'(want.normal_v));
      if (got.tangent_u !== want.tangent_u)
        report_mismatch("tangent_u", 32'(got.tangent_u), 32'(want.tangent_u));
      if (got.tangent_v !== want.tangent_v)
        report_mismatch("tangent_v", 32'(got.tangent_v), 32'(want.tangent_v));
      if (got.tangent_mid !== want.tangent_mid)
        report_mismatch("tangent_mid", 32'(got.tangent_mid), 32'(want.tangent_mid));
      if (got.tangent_sign !== want.tangent_sign)
        report_mismatch("tangent_sign", 32'(got.tangent_sign), 32'(want.tangent_sign));
      if (got.zero_vector !== want.zero_vector)
        report_mismatch("zero_vector", 32'(got.zero_vector), 32'(want.zero_vector));
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycles         = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_requests  = 0;
  int   hold_served    = 0;
  int   hold_left      = 0;

  octa_code_tracker tracker = new();
  enc_code_t        seen_code;

  ove_in_if  vec_in();
  ove_out_if enc_out();

  octahedral_vector_encoder_top DUT (
    .clk     (clk),
    .rst     (rst),
    .vec_in  (vec_in),
    .enc_out (enc_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, tracker.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    enc_out.ready <= 1'b0;
    forever @(posedge clk) begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        enc_out.ready <= 1'b0;
        hold_left--;
      end else begin
        enc_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result monitor: signals are stable mid-cycle, the transaction lands on the next edge
  always @(negedge clk) begin
    if (rst === 1'b0 && enc_out.valid === 1'b1 && enc_out.ready === 1'b1) begin
      seen_code.normal_u     = enc_out.normal_u;
      seen_code.normal_v     = enc_out.normal_v;
      seen_code.tangent_u    = enc_out.tangent_u;
      seen_code.tangent_v    = enc_out.tangent_v;
      seen_code.tangent_mid  = enc_out.tangent_mid;
      seen_code.tangent_sign = enc_out.tangent_sign;
      seen_code.zero_vector  = enc_out.zero_vector;
      tracker.check_code(seen_code);
    end
  end

  // offer one vector, with random idle cycles ahead of it, and wait for the transaction
  task automatic send_vector(ove_pkg::comp_t x, ove_pkg::comp_t y, ove_pkg::comp_t z,
                             logic hand);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      vec_in.valid <= 1'b0;
      @(posedge clk);
    end
    vec_in.valid      <= 1'b1;
    vec_in.vec_x      <= x;
    vec_in.vec_y      <= y;
    vec_in.vec_z      <= z;
    vec_in.handedness <= hand;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (vec_in.valid === 1'b1 && vec_in.ready === 1'b1);
      @(posedge clk);
    end
    tracker.note_vector(x, y, z, hand);
  endtask

  // sender pauses until every pending result has come back
  task automatic wait_drained();
    vec_in.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // one component drawn from a value class
  function automatic ove_pkg::comp_t pick_component(int kind);
    ove_pkg::comp_t edges[7];
    edges = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF};
    case (kind)
      0: return ove_pkg::comp_t'($urandom);
      1: return ove_pkg::comp_t'(int'($urandom_range(16)) - 8);
      2: return edges[$urandom_range(6)];
      3: return '0;
      default: return ove_pkg::comp_t'((int'($urandom_range(6)) - 3) *
                                       int'($urandom_range(1, 10000)));
    endcase
  endfunction

  task automatic send_random();
    ove_pkg::comp_t x, y, z;
    int             mode;
    mode = $urandom_range(9);
    case (mode)
      0, 1, 2, 3: begin
        x = pick_component(0);
        y = pick_component(0);
        z = pick_component(0);
      end
      4: begin
        x = pick_component(1);
        y = pick_component(1);
        z = pick_component(1);
      end
      5, 6: begin
        x = pick_component($urandom_range(4));
        y = pick_component($urandom_range(4));
        z = pick_component($urandom_range(4));
      end
      7: begin
        x = pick_component(4);
        y = pick_component(4);
        z = pick_component(4);
      end
      8: begin
        // lower hemisphere
        x = pick_component($urandom_range(4));
        y = pick_component($urandom_range(4));
        z = ove_pkg::comp_t'(-1 - int'($urandom_range(32767)));
      end
      default: begin
        x = pick_component(2);
        y = pick_component(2);
        z = pick_component(2);
      end
    endcase
    send_vector(x, y, z, 1'($urandom_range(1)));
  endtask

  // main sequence
  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 65, 0, 9};
    recv_pcts = '{0, 0, 65, 9};

    rst               <= 1'b1;
    vec_in.valid      <= 1'b0;
    vec_in.vec_x      <= '0;
    vec_in.vec_y      <= '0;
    vec_in.vec_z      <= '0;
    vec_in.handedness <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, extremes, fold with zero components, rounding ties
    send_vector('0, '0, '0, 1'b1);
    send_vector('0, '0, '0, 1'b0);
    send_vector(16'h7FFF, '0, '0, 1'b1);
    send_vector(16'h8000, '0, '0, 1'b0);
    send_vector('0, 16'h8000, '0, 1'b1);
    send_vector('0, 16'h7FFF, '0, 1'b0);
    send_vector('0, '0, 16'h8000, 1'b1);
    send_vector('0, '0, 16'h7FFF, 1'b0);
    send_vector(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_vector(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_vector(ove_pkg::comp_t'(1), ove_pkg::comp_t'(1), ove_pkg::comp_t'(-1), 1'b0);
    send_vector(ove_pkg::comp_t'(1), ove_pkg::comp_t'(-1), ove_pkg::comp_t'(-2), 1'b1);
    send_vector(ove_pkg::comp_t'(-3), ove_pkg::comp_t'(5), ove_pkg::comp_t'(-7), 1'b0);
    send_vector(ove_pkg::comp_t'(1), ove_pkg::comp_t'(1), '0, 1'b1);
    send_vector(ove_pkg::comp_t'(-1), ove_pkg::comp_t'(-1), '0, 1'b0);
    send_vector(ove_pkg::comp_t'(1), '0, ove_pkg::comp_t'(1), 1'b1);
    send_vector(ove_pkg::comp_t'(-1), '0, ove_pkg::comp_t'(1), 1'b0);
    send_vector('0, ove_pkg::comp_t'(1), ove_pkg::comp_t'(-1), 1'b1);
    send_vector(ove_pkg::comp_t'(-1), '0, ove_pkg::comp_t'(-1), 1'b0);
    send_vector(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_vector(ove_pkg::comp_t'(5), ove_pkg::comp_t'(-5), '0, 1'b0);
    send_vector(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    send_vector(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    wait_drained();

    // random passes over the idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      // long receiver hold-off while the sender keeps offering
      if (p == 0 || p == 2) hold_requests++;
      for (int i = 0; i < ITEMS_PER_PASS; i++) send_random();
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.pending() != 0)
      tracker.report_mismatch("results never returned", tracker.pending(), 0);

    $display("run covered %0d vectors and %0d checked results across four idle/stall mixes",
             tracker.vectors_in, tracker.codes_out);
    $display("including %0d zero vectors and %0d folded lower-hemisphere vectors, %0d errors",
             tracker.zero_seen, tracker.folded_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== octahedral_vector_encoder_top.f =====
design/ove_pkg.sv
design/ove_if.sv
design/ove_front.sv
design/ove_div_stage.sv
design/ove_pack.sv
design/octahedral_vector_encoder_top.sv
verif/tb_octahedral_vector_encoder_top.sv
